>>> src/btis_pkg.sv
// Package for the breath test interlock sequencer.
// Holds the state codes, message codes, register indexes and shared structs.
// No dependencies.
package btis_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned MaxMsgs = 4;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegSamplePeriod = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegMeasureTime  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegSeatLost     = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegResultTo     = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegRetryDelay   = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegHumPeriod    = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegMaxFails     = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegHumReads     = 3'd7;

  // machine states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StWSeat = 4'd1;
  localparam logic [3:0] StSLost = 4'd2;
  localparam logic [3:0] StWBlow = 4'd3;
  localparam logic [3:0] StRetry = 4'd4;
  localparam logic [3:0] StMeas  = 4'd5;
  localparam logic [3:0] StWRes  = 4'd6;
  localparam logic [3:0] StPass  = 4'd7;
  localparam logic [3:0] StFail  = 4'd8;

  // message codes
  localparam logic [3:0] MsgNone    = 4'd0;
  localparam logic [3:0] MsgStart   = 4'd1;
  localparam logic [3:0] MsgSeatOn  = 4'd2;
  localparam logic [3:0] MsgSeatOff = 4'd3;
  localparam logic [3:0] MsgBlow    = 4'd4;
  localparam logic [3:0] MsgBegin   = 4'd5;
  localparam logic [3:0] MsgEnd     = 4'd6;
  localparam logic [3:0] MsgFail    = 4'd7;
  localparam logic [3:0] MsgError   = 4'd8;
  localparam logic [3:0] MsgGas     = 4'd9;
  localparam logic [3:0] MsgHum     = 4'd10;
  localparam logic [3:0] MsgSensErr = 4'd11;

  // host commands
  localparam logic [2:0] CmdPass  = 3'd0;
  localparam logic [2:0] CmdFail  = 3'd1;
  localparam logic [2:0] CmdError = 3'd2;
  localparam logic [2:0] CmdRetry = 3'd3;
  localparam logic [2:0] CmdOther = 3'd4;

  // blink half periods
  localparam int unsigned BlinkBlow = 500;
  localparam int unsigned BlinkMeas = 100;
  localparam int unsigned BlinkWRes = 300;

  typedef struct packed {
    logic       operation;
    logic [2:0] command;
    logic       start_level;
    logic       blow_level;
    logic       seat_occupied;
    logic [11:0] gas_sample;
    logic [6:0] humidity_value;
    logic       humidity_ok;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  message;
    logic [11:0] sample_value;
    logic [3:0]  machine_state;
    logic        green_led;
    logic        yellow_led;
    logic        red_led;
    logic        engine_enable;
    logic        buzzer_trigger;
    logic        last;
  } out_word_t;

  // one processed item: up to four messages plus the common status
  typedef struct packed {
    logic [2:0]           count;   // 1..4
    logic [3:0][3:0]      code;
    logic [3:0][11:0]     value;
    logic [3:0]           state;
    logic [2:0]           leds;    // {red, yellow, green}
    logic                 engine;
    logic                 buzz;
  } batch_t;

endpackage

>>> src/btis_if.sv
// Valid/ready channel interface carrying one word of type T.
// Depends on nothing; payload type is set by the user.
interface btis_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/btis_front.sv
// Front part: accepts words, runs the interlock state machine, builds batches.
// Depends on btis_pkg.
module btis_front #(
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [btis_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [btis_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  btis_pkg::in_word_t           in_data_i,
  output logic                         b_valid_o,
  input  logic                         b_ready_i,
  output btis_pkg::batch_t             b_data_o
);
  typedef logic [TIME_BITS-1:0] tm_t;
  localparam int unsigned BlinkBits = 9;
  localparam int unsigned SampleCut = (SAMPLE_BITS < 12) ? SAMPLE_BITS : 12;

  // configuration registers
  logic [15:0] cfg_q [6];
  logic [2:0]  max_fails_q, hum_reads_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= 16'd100;
      cfg_q[1] <= 16'd5000;
      cfg_q[2] <= 16'd10000;
      cfg_q[3] <= 16'd10000;
      cfg_q[4] <= 16'd5000;
      cfg_q[5] <= 16'd1000;
      max_fails_q <= 3'd3;
      hum_reads_q <= 3'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        btis_pkg::RegMaxFails: max_fails_q <= cfg_data_i[2:0];
        btis_pkg::RegHumReads: hum_reads_q <= cfg_data_i[2:0];
        default: cfg_q[cfg_idx_i[2:0]] <= cfg_data_i;
      endcase
    end
  end

  // blink phase counters replace now/half divisions; they track now_ms mod 2*half
  logic [BlinkBits:0] ph500_q, ph500_d;
  logic [BlinkBits:0] ph100_q, ph100_d;
  logic [BlinkBits:0] ph300_q, ph300_d;

  logic [3:0] mode_q, mode_d;
  tm_t now_q, now_d, entry_q, entry_d, mstart_q, mstart_d, lgas_q, lgas_d;
  tm_t lhum_q, lhum_d, slost_q, slost_d, rstart_q, rstart_d, empty_q, empty_d;
  logic [2:0] hdone_q, hdone_d, fails_q, fails_d;
  logic empty_v_q, empty_v_d, sprev_q, sprev_d, bprev_q, bprev_d;
  logic begin_q, begin_d, fbeep_q, fbeep_d, bpend_q, bpend_d;
  logic [2:0] leds_q, leds_d;
  logic eng_q, eng_d;

  logic out_full_q;
  btis_pkg::batch_t out_q, bat;
  logic take;

  assign in_ready_o = !out_full_q || b_ready_i;
  assign take = in_valid_i && in_ready_o;
  assign b_valid_o = out_full_q;
  assign b_data_o = out_q;

  function automatic logic [BlinkBits:0] adv(logic [BlinkBits:0] p, int unsigned half);
    logic [BlinkBits:0] lim;
    lim = (BlinkBits+1)'(2*half - 1);
    return (p == lim) ? '0 : p + 1'b1;
  endfunction

  function automatic logic ge(tm_t d, logic [15:0] lim);
    return d >= tm_t'(lim);
  endfunction

  always_comb begin
    logic [2:0] n;
    logic start_pr, blow_pr, seat, go_f;
    logic [3:0] go_s;
    tm_t nw;
    mode_d = mode_q; now_d = now_q; entry_d = entry_q; mstart_d = mstart_q;
    lgas_d = lgas_q; lhum_d = lhum_q; slost_d = slost_q; rstart_d = rstart_q;
    empty_d = empty_q; hdone_d = hdone_q; fails_d = fails_q; empty_v_d = empty_v_q;
    sprev_d = sprev_q; bprev_d = bprev_q; begin_d = begin_q; fbeep_d = fbeep_q;
    bpend_d = bpend_q; leds_d = leds_q; eng_d = eng_q;
    ph500_d = ph500_q; ph100_d = ph100_q; ph300_d = ph300_q;
    bat = '0;
    n = '0; go_f = 1'b0; go_s = btis_pkg::StIdle;
    seat = in_data_i.seat_occupied;
    start_pr = 1'b0; blow_pr = 1'b0;
    nw = now_q;
    if (in_data_i.operation) begin
      case (in_data_i.command)
        btis_pkg::CmdPass: begin go_f = 1'b1; go_s = btis_pkg::StPass; end
        btis_pkg::CmdFail: begin
          if (fails_q != 3'd7) fails_d = fails_q + 3'd1;
          go_f = 1'b1;
          if (fails_d < max_fails_q) begin
            rstart_d = nw; go_s = btis_pkg::StRetry;
          end else go_s = btis_pkg::StFail;
        end
        btis_pkg::CmdError: begin
          mstart_d = '0; lgas_d = '0; hdone_d = '0;
          go_f = 1'b1; go_s = btis_pkg::StIdle;
        end
        btis_pkg::CmdRetry: begin
          rstart_d = nw; fbeep_d = 1'b0; go_f = 1'b1; go_s = btis_pkg::StRetry;
        end
        btis_pkg::CmdOther: bpend_d = 1'b1;
        default: ;
      endcase
    end else begin
      nw = now_q + 1'b1;
      now_d = nw;
      ph500_d = adv(ph500_q, btis_pkg::BlinkBlow);
      ph100_d = adv(ph100_q, btis_pkg::BlinkMeas);
      ph300_d = adv(ph300_q, btis_pkg::BlinkWRes);
      // phases restart with the clock when it wraps
      if (nw == '0) begin
        ph500_d = '0; ph100_d = '0; ph300_d = '0;
      end
      if (bpend_q) begin bpend_d = 1'b0; bat.buzz = 1'b1; end
      start_pr = sprev_q && !in_data_i.start_level;
      blow_pr = bprev_q && !in_data_i.blow_level;
      sprev_d = in_data_i.start_level;
      bprev_d = in_data_i.blow_level;
      case (mode_q)
        btis_pkg::StWSeat: begin
          leds_d = leds_q | 3'b010;
          if (seat) begin
            bat.code[n[1:0]] = btis_pkg::MsgSeatOn; n = n + 3'd1;
            go_f = 1'b1; go_s = btis_pkg::StWBlow;
          end
        end
        btis_pkg::StSLost: begin
          leds_d = 3'b100;
          if (seat) begin
            bat.code[n[1:0]] = btis_pkg::MsgSeatOn; n = n + 3'd1;
            mstart_d = '0; lgas_d = '0; lhum_d = nw - tm_t'(cfg_q[5]); hdone_d = '0;
            go_f = 1'b1; go_s = btis_pkg::StWBlow;
          end else if (ge(nw - slost_q, cfg_q[2])) begin
            bat.code[n[1:0]] = btis_pkg::MsgFail; n = n + 3'd1;
            go_f = 1'b1; go_s = btis_pkg::StFail;
          end
        end
        btis_pkg::StRetry: begin
          leds_d = 3'b111;
          if (ge(nw - rstart_q, cfg_q[4])) begin
            mstart_d = '0; lgas_d = '0; lhum_d = nw - tm_t'(cfg_q[5]); hdone_d = '0;
            go_f = 1'b1; go_s = btis_pkg::StWBlow;
          end
        end
        btis_pkg::StWBlow: begin
          leds_d = ph500_d[BlinkBits:0] >= (BlinkBits+1)'(btis_pkg::BlinkBlow)
                   ? (leds_q | 3'b010) : 3'b000;
          if (!seat) begin
            bat.code[n[1:0]] = btis_pkg::MsgSeatOff; n = n + 3'd1;
            slost_d = nw; go_f = 1'b1; go_s = btis_pkg::StSLost;
          end else if (blow_pr) begin
            bat.code[n[1:0]] = btis_pkg::MsgBlow; n = n + 3'd1;
            lgas_d = '0; lhum_d = nw - tm_t'(cfg_q[5]); hdone_d = '0;
            mstart_d = nw; go_f = 1'b1; go_s = btis_pkg::StMeas;
          end
        end
        btis_pkg::StMeas: begin
          if (!begin_q) begin
            bat.code[n[1:0]] = btis_pkg::MsgBegin; n = n + 3'd1; begin_d = 1'b1;
          end
          leds_d = ph100_d >= (BlinkBits+1)'(btis_pkg::BlinkMeas)
                   ? (leds_q | 3'b010) : 3'b000;
          if (!seat) begin
            bat.code[n[1:0]] = btis_pkg::MsgSeatOff; n = n + 3'd1;
            slost_d = nw; go_f = 1'b1; go_s = btis_pkg::StSLost;
          end else begin
            if (ge(nw - lgas_q, cfg_q[0])) begin
              lgas_d = nw;
              bat.code[n[1:0]] = btis_pkg::MsgGas;
              bat.value[n[1:0]] = 12'(in_data_i.gas_sample[SampleCut-1:0]);
              n = n + 3'd1;
            end
            if (ge(nw - lhum_q, cfg_q[5]) && hdone_q < hum_reads_q) begin
              lhum_d = nw;
              if (in_data_i.humidity_ok) begin
                bat.code[n[1:0]] = btis_pkg::MsgHum;
                bat.value[n[1:0]] = 12'(in_data_i.humidity_value);
              end else bat.code[n[1:0]] = btis_pkg::MsgSensErr;
              n = n + 3'd1;
              hdone_d = hdone_q + 3'd1;
            end
            if (ge(nw - mstart_q, cfg_q[1])) begin
              bat.code[n[1:0]] = btis_pkg::MsgEnd; n = n + 3'd1;
              go_f = 1'b1; go_s = btis_pkg::StWRes;
            end
          end
        end
        btis_pkg::StWRes: begin
          if (ge(nw - entry_q, cfg_q[3])) begin
            bat.code[n[1:0]] = btis_pkg::MsgError; n = n + 3'd1;
            go_f = 1'b1; go_s = btis_pkg::StIdle;
          end else begin
            leds_d = ph300_d >= (BlinkBits+1)'(btis_pkg::BlinkWRes)
                     ? (leds_q | 3'b010) : 3'b000;
            if (!seat) begin
              bat.code[n[1:0]] = btis_pkg::MsgSeatOff; n = n + 3'd1;
              slost_d = nw; go_f = 1'b1; go_s = btis_pkg::StSLost;
            end
          end
        end
        btis_pkg::StPass: begin
          fails_d = '0; leds_d = 3'b001; eng_d = 1'b1;
          if (start_pr) begin
            eng_d = 1'b0; empty_v_d = 1'b0;
            bat.code[n[1:0]] = btis_pkg::MsgStart; n = n + 3'd1;
            go_f = 1'b1; go_s = btis_pkg::StWSeat;
          end else if (!seat) begin
            empty_d = empty_v_q ? empty_q : nw;
            empty_v_d = 1'b1;
            if (ge(nw - empty_d, cfg_q[2])) begin
              bat.code[n[1:0]] = btis_pkg::MsgSeatOff; n = n + 3'd1;
              go_f = 1'b1; go_s = btis_pkg::StIdle;
            end
          end else empty_v_d = 1'b0;
        end
        btis_pkg::StFail: begin
          leds_d = 3'b100; eng_d = 1'b0;
          if (!fbeep_q) begin bat.buzz = 1'b1; fbeep_d = 1'b1; end
          if (start_pr) begin go_f = 1'b1; go_s = btis_pkg::StIdle; end
        end
        default: begin
          leds_d = '0; eng_d = 1'b0; mode_d = btis_pkg::StIdle; empty_v_d = 1'b0;
          fails_d = '0; mstart_d = '0; lgas_d = '0; hdone_d = '0;
          slost_d = '0; rstart_d = '0; begin_d = 1'b0;
          if (start_pr) begin
            bat.code[n[1:0]] = btis_pkg::MsgStart; n = n + 3'd1;
            go_f = 1'b1; go_s = btis_pkg::StWSeat;
          end
        end
      endcase
    end
    // state change
    if (go_f) begin
      mode_d = go_s; entry_d = nw; leds_d = '0;
      if (go_s != btis_pkg::StMeas) begin_d = 1'b0;
      if (go_s != btis_pkg::StFail) fbeep_d = 1'b0;
      if (go_s != btis_pkg::StPass) eng_d = 1'b0;
    end
    if (n == 3'd0) begin bat.code[0] = btis_pkg::MsgNone; n = 3'd1; end
    bat.count = n;
    bat.state = mode_d;
    bat.leds = leds_d;
    bat.engine = eng_d;
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= btis_pkg::StIdle;
      now_q <= '0; entry_q <= '0; mstart_q <= '0; lgas_q <= '0; lhum_q <= '0;
      slost_q <= '0; rstart_q <= '0; empty_q <= '0;
      hdone_q <= '0; fails_q <= '0; empty_v_q <= 1'b0;
      sprev_q <= 1'b1; bprev_q <= 1'b1;
      begin_q <= 1'b0; fbeep_q <= 1'b0; bpend_q <= 1'b0;
      leds_q <= '0; eng_q <= 1'b0;
      ph500_q <= '0; ph100_q <= '0; ph300_q <= '0;
      out_full_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q <= mode_d; now_q <= now_d; entry_q <= entry_d; mstart_q <= mstart_d;
        lgas_q <= lgas_d; lhum_q <= lhum_d; slost_q <= slost_d; rstart_q <= rstart_d;
        empty_q <= empty_d; hdone_q <= hdone_d; fails_q <= fails_d;
        empty_v_q <= empty_v_d; sprev_q <= sprev_d; bprev_q <= bprev_d;
        begin_q <= begin_d; fbeep_q <= fbeep_d; bpend_q <= bpend_d;
        leds_q <= leds_d; eng_q <= eng_d;
        ph500_q <= ph500_d; ph100_q <= ph100_d; ph300_q <= ph300_d;
      end
      if (take) out_full_q <= 1'b1;
      else if (b_ready_i) out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) out_q <= bat;
  end
endmodule

>>> src/btis_back.sv
// Back part: takes batches and emits one result word per message.
// Depends on btis_pkg.
module btis_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              b_valid_i,
  output logic              b_ready_o,
  input  btis_pkg::batch_t  b_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output btis_pkg::out_word_t out_data_o
);
  btis_pkg::batch_t cur_q;
  logic busy_q;
  logic [1:0] idx_q;
  logic last_w, pop;

  assign last_w = (3'(idx_q) + 3'd1) == cur_q.count;
  assign pop = busy_q && out_ready_i;
  assign b_ready_o = !busy_q || (pop && last_w);
  assign out_valid_o = busy_q;

  always_comb begin
    out_data_o.message = cur_q.code[idx_q];
    out_data_o.sample_value = cur_q.value[idx_q];
    out_data_o.machine_state = cur_q.state;
    out_data_o.green_led = cur_q.leds[0];
    out_data_o.yellow_led = cur_q.leds[1];
    out_data_o.red_led = cur_q.leds[2];
    out_data_o.engine_enable = cur_q.engine;
    out_data_o.buzzer_trigger = cur_q.buzz && (idx_q == 2'd0);
    out_data_o.last = last_w;
  end

  // message sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q <= '0;
    end else if (b_valid_i && b_ready_o) begin
      busy_q <= 1'b1;
      idx_q <= '0;
    end else if (pop) begin
      if (last_w) busy_q <= 1'b0;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_i && b_ready_o) cur_q <= b_data_i;
  end
endmodule

>>> src/breath_test_interlock_sequencer.sv
// Top level of the breath test interlock sequencer.
// Depends on btis_pkg, btis_if, btis_front and btis_back.
//
// Usage: in_if carries input words (a 1 ms tick with pin readings, or a host
// command); out_if carries result words. Each input word yields one to four
// result words; the final one has last set. The user must write registers
// through cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle; the
// block itself does not enforce it. With the back part free, an accepted
// input word is registered into the batch register and then into the message
// sequencer, which presents its first result word.
// Throughput: one result word per cycle from the back part while out_if
// is ready; an input word's results (1 to 4) leave one at a time through the
// single output port of the message sequencer. The front takes a new word
// while the back is still sending, via a one-entry batch register between them.
// Reset: machine idle, timers zero, registers at their defaults, no output.
// A stalled receiver holds the current result; the front fills the batch
// register and then deasserts ready until space frees.
module breath_test_interlock_sequencer #(
  parameter int unsigned TIME_BITS   = 32,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [btis_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [btis_pkg::CfgDataBits-1:0] cfg_data_i,
  btis_if.sink   in_if,
  btis_if.source out_if
);
  logic b_valid, b_ready;
  btis_pkg::batch_t b_data;

  btis_front #(.TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .b_valid_o(b_valid), .b_ready_i(b_ready), .b_data_o(b_data)
  );

  btis_back u_back (
    .clk_i, .rst_ni,
    .b_valid_i(b_valid), .b_ready_o(b_ready), .b_data_i(b_data),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(out_if.data)
  );
endmodule

>>> src/btis_checker.sv
// Port checker for the breath test interlock sequencer, bound to the top.
// Depends on btis_pkg.
module btis_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input btis_pkg::out_word_t out_data
);
  // engine only runs in pass
  a_engine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.engine_enable |-> out_data.machine_state == btis_pkg::StPass)
    else $error("engine enabled outside pass");
  // held result while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  // buzzer only on the first word of an item
  a_buzz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_data.last |=> !out_valid || !out_data.buzzer_trigger)
    else $error("buzzer on a later word");
  // sample value only for gas and humidity
  a_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.sample_value != '0 |->
      out_data.message == btis_pkg::MsgGas || out_data.message == btis_pkg::MsgHum)
    else $error("sample value on wrong message");
endmodule

bind breath_test_interlock_sequencer btis_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid(out_if.valid),
  .out_ready(out_if.ready), .out_data(out_if.data)
);

>>> test/breath_test_interlock_sequencer_tb.sv
// Self-checking testbench for the breath test interlock sequencer.
// Depends on btis_pkg, btis_if and breath_test_interlock_sequencer.
// A steered random generator walks the state machine; an in-line predictor checks every word.
module breath_test_interlock_sequencer_tb;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [btis_pkg::CfgIdxBits-1:0] cfg_idx;
  logic [btis_pkg::CfgDataBits-1:0] cfg_data;

  btis_if #(.T(btis_pkg::in_word_t))  in_ch  ();
  btis_if #(.T(btis_pkg::out_word_t)) out_ch ();

  breath_test_interlock_sequencer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // pending input words and the result words they should produce
  btis_pkg::in_word_t  pending_words[$];
  btis_pkg::out_word_t expected_words[$];
  int        mismatches;
  int        in_gap;
  int        out_wait;

  // interlock shadow: registers and machine state
  logic [15:0] reg_val[btis_pkg::NumRegs];
  logic [3:0]  m_mode;
  logic [31:0] now_ms, entry_ms, meas_start_ms, last_gas_ms, last_hum_ms;
  logic [31:0] seat_lost_ms, retry_start_ms, empty_ms;
  logic [2:0]  hum_done, fails_seen;
  logic        empty_valid, start_prev, blow_prev, begin_sent, fail_beeped, beep_pending;
  logic [2:0]  lamps;  // {red, yellow, green}
  logic        engine_drv;
  int          n_msg;
  logic [3:0]  msg_code[4];
  logic [11:0] msg_val[4];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int draw_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 10);
  endfunction

  function automatic void emit(logic [3:0] code, logic [11:0] val);
    if (n_msg < 4) begin
      msg_code[n_msg] = code;
      msg_val[n_msg] = val;
      n_msg++;
    end
  endfunction

  function automatic logic [31:0] since(logic [31:0] t);
    return now_ms - t;
  endfunction

  function automatic void enter(logic [3:0] s);
    m_mode = s;
    entry_ms = now_ms;
    if (s != btis_pkg::StMeas) begin_sent = 1'b0;
    if (s != btis_pkg::StFail) fail_beeped = 1'b0;
    if (s != btis_pkg::StPass) engine_drv = 1'b0;
    lamps = 3'b000;
  endfunction

  function automatic void clear_measure();
    meas_start_ms = '0;
    last_gas_ms = '0;
    last_hum_ms = now_ms - 32'(reg_val[btis_pkg::RegHumPeriod]);
    hum_done = '0;
  endfunction

  function automatic void blink(int unsigned half);
    lamps = ((now_ms / half) % 2 == 1) ? (lamps | 3'b010) : 3'b000;
  endfunction

  function automatic void model_reset();
    reg_val[btis_pkg::RegSamplePeriod] = 100;
    reg_val[btis_pkg::RegMeasureTime] = 5000;
    reg_val[btis_pkg::RegSeatLost] = 10000;
    reg_val[btis_pkg::RegResultTo] = 10000;
    reg_val[btis_pkg::RegRetryDelay] = 5000;
    reg_val[btis_pkg::RegHumPeriod] = 1000;
    reg_val[btis_pkg::RegMaxFails] = 3;
    reg_val[btis_pkg::RegHumReads] = 5;
    m_mode = btis_pkg::StIdle;
    {now_ms, entry_ms, meas_start_ms, last_gas_ms, last_hum_ms} = '0;
    {seat_lost_ms, retry_start_ms, empty_ms} = '0;
    hum_done = '0;
    fails_seen = '0;
    empty_valid = 1'b0;
    start_prev = 1'b1;
    blow_prev = 1'b1;
    {begin_sent, fail_beeped, beep_pending} = '0;
    lamps = '0;
    engine_drv = 1'b0;
  endfunction

  function automatic void host_command(logic [2:0] c);
    case (c)
      btis_pkg::CmdPass: enter(btis_pkg::StPass);
      btis_pkg::CmdFail: begin
        if (fails_seen < 7) fails_seen++;
        if (16'(fails_seen) < reg_val[btis_pkg::RegMaxFails]) begin
          retry_start_ms = now_ms;
          enter(btis_pkg::StRetry);
        end else begin
          enter(btis_pkg::StFail);
        end
      end
      btis_pkg::CmdError: begin
        meas_start_ms = '0;
        last_gas_ms = '0;
        hum_done = '0;
        enter(btis_pkg::StIdle);
      end
      btis_pkg::CmdRetry: begin
        retry_start_ms = now_ms;
        fail_beeped = 1'b0;
        enter(btis_pkg::StRetry);
      end
      btis_pkg::CmdOther: beep_pending = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic logic ms_tick(btis_pkg::in_word_t w);
    logic buzz, start_pr, blow_pr, seat;
    buzz = 1'b0;
    seat = w.seat_occupied;
    now_ms = now_ms + 32'd1;
    if (beep_pending) begin
      beep_pending = 1'b0;
      buzz = 1'b1;
    end
    start_pr = start_prev && !w.start_level;
    blow_pr = blow_prev && !w.blow_level;
    start_prev = w.start_level;
    blow_prev = w.blow_level;
    case (m_mode)
      btis_pkg::StWSeat: begin
        lamps |= 3'b010;
        if (seat) begin emit(btis_pkg::MsgSeatOn, 0); enter(btis_pkg::StWBlow); end
      end
      btis_pkg::StSLost: begin
        lamps = 3'b100;
        if (seat) begin
          emit(btis_pkg::MsgSeatOn, 0);
          clear_measure();
          enter(btis_pkg::StWBlow);
        end else if (since(seat_lost_ms) >= 32'(reg_val[btis_pkg::RegSeatLost])) begin
          emit(btis_pkg::MsgFail, 0);
          enter(btis_pkg::StFail);
        end
      end
      btis_pkg::StRetry: begin
        lamps = 3'b111;
        if (since(retry_start_ms) >= 32'(reg_val[btis_pkg::RegRetryDelay])) begin
          clear_measure();
          blow_prev = w.blow_level;
          enter(btis_pkg::StWBlow);
        end
      end
      btis_pkg::StWBlow: begin
        blink(btis_pkg::BlinkBlow);
        if (!seat) begin
          emit(btis_pkg::MsgSeatOff, 0);
          seat_lost_ms = now_ms;
          enter(btis_pkg::StSLost);
        end else if (blow_pr) begin
          emit(btis_pkg::MsgBlow, 0);
          clear_measure();
          meas_start_ms = now_ms;
          enter(btis_pkg::StMeas);
        end
      end
      btis_pkg::StMeas: begin
        if (!begin_sent) begin emit(btis_pkg::MsgBegin, 0); begin_sent = 1'b1; end
        blink(btis_pkg::BlinkMeas);
        if (!seat) begin
          emit(btis_pkg::MsgSeatOff, 0);
          seat_lost_ms = now_ms;
          enter(btis_pkg::StSLost);
        end else begin
          if (since(last_gas_ms) >= 32'(reg_val[btis_pkg::RegSamplePeriod])) begin
            last_gas_ms = now_ms;
            emit(btis_pkg::MsgGas, w.gas_sample);
          end
          if (since(last_hum_ms) >= 32'(reg_val[btis_pkg::RegHumPeriod]) &&
              16'(hum_done) < reg_val[btis_pkg::RegHumReads]) begin
            last_hum_ms = now_ms;
            if (w.humidity_ok) emit(btis_pkg::MsgHum, 12'(w.humidity_value));
            else emit(btis_pkg::MsgSensErr, 0);
            hum_done = hum_done + 3'd1;
          end
          if (since(meas_start_ms) >= 32'(reg_val[btis_pkg::RegMeasureTime])) begin
            emit(btis_pkg::MsgEnd, 0);
            enter(btis_pkg::StWRes);
          end
        end
      end
      btis_pkg::StWRes: begin
        if (since(entry_ms) >= 32'(reg_val[btis_pkg::RegResultTo])) begin
          emit(btis_pkg::MsgError, 0);
          enter(btis_pkg::StIdle);
        end else begin
          blink(btis_pkg::BlinkWRes);
          if (!seat) begin
            emit(btis_pkg::MsgSeatOff, 0);
            seat_lost_ms = now_ms;
            enter(btis_pkg::StSLost);
          end
        end
      end
      btis_pkg::StPass: begin
        fails_seen = '0;
        lamps = 3'b001;
        engine_drv = 1'b1;
        if (start_pr) begin
          engine_drv = 1'b0;
          empty_valid = 1'b0;
          emit(btis_pkg::MsgStart, 0);
          enter(btis_pkg::StWSeat);
        end else if (!seat) begin
          if (!empty_valid) begin
            empty_valid = 1'b1;
            empty_ms = now_ms;
          end
          if (since(empty_ms) >= 32'(reg_val[btis_pkg::RegSeatLost])) begin
            emit(btis_pkg::MsgSeatOff, 0);
            enter(btis_pkg::StIdle);
          end
        end else begin
          empty_valid = 1'b0;
        end
      end
      btis_pkg::StFail: begin
        lamps = 3'b100;
        engine_drv = 1'b0;
        if (!fail_beeped) begin buzz = 1'b1; fail_beeped = 1'b1; end
        if (start_pr) enter(btis_pkg::StIdle);
      end
      default: begin
        lamps = '0;
        engine_drv = 1'b0;
        m_mode = btis_pkg::StIdle;
        empty_valid = 1'b0;
        fails_seen = '0;
        meas_start_ms = '0;
        last_gas_ms = '0;
        hum_done = '0;
        seat_lost_ms = '0;
        retry_start_ms = '0;
        begin_sent = 1'b0;
        if (start_pr) begin emit(btis_pkg::MsgStart, 0); enter(btis_pkg::StWSeat); end
      end
    endcase
    return buzz;
  endfunction

  // predict the words for one input and queue it for the driver
  task automatic send(btis_pkg::in_word_t w);
    logic buzz;
    btis_pkg::out_word_t o;
    buzz = 1'b0;
    n_msg = 0;
    if (w.operation) host_command(w.command);
    else buzz = ms_tick(w);
    if (n_msg == 0) emit(btis_pkg::MsgNone, 0);
    for (int k = 0; k < n_msg; k++) begin
      o.message = msg_code[k];
      o.sample_value = msg_val[k];
      o.machine_state = m_mode;
      o.green_led = lamps[0];
      o.yellow_led = lamps[1];
      o.red_led = lamps[2];
      o.engine_enable = engine_drv;
      o.buzzer_trigger = (k == 0) && buzz;
      o.last = (k == n_msg - 1);
      expected_words.push_back(o);
    end
    pending_words.push_back(w);
  endtask

  function automatic btis_pkg::in_word_t mk_tick(logic st, logic bl, logic seat,
                                       logic [11:0] gas, logic [6:0] hum, logic ok);
    btis_pkg::in_word_t w;
    w = '0;
    w.command = 3'($urandom_range(0, 7));
    w.start_level = st;
    w.blow_level = bl;
    w.seat_occupied = seat;
    w.gas_sample = gas;
    w.humidity_value = hum;
    w.humidity_ok = ok;
    return w;
  endfunction

  function automatic btis_pkg::in_word_t mk_cmd(logic [2:0] c);
    btis_pkg::in_word_t w;
    w = btis_pkg::in_word_t'($urandom());
    w.operation = 1'b1;
    w.command = c;
    return w;
  endfunction

  // one random word steered by the shadow state toward deep behavior
  function automatic btis_pkg::in_word_t steer();
    btis_pkg::in_word_t w;
    logic [2:0] verdicts[5];
    logic press_s, press_b, seat;
    verdicts = '{btis_pkg::CmdPass, btis_pkg::CmdFail, btis_pkg::CmdRetry,
                 btis_pkg::CmdError, btis_pkg::CmdOther};
    if ($urandom_range(0, 9) == 0) begin
      w = btis_pkg::in_word_t'($urandom());
      return w;
    end
    if ($urandom_range(0, 29) == 0) return mk_cmd(3'($urandom_range(0, 7)));
    if (m_mode == btis_pkg::StWRes && $urandom_range(0, 3) == 0)
      return mk_cmd(verdicts[$urandom_range(0, 4)]);
    press_s = ($urandom_range(0, 2) == 0);
    press_b = ($urandom_range(0, 1) == 0);
    seat = ($urandom_range(0, 11) != 0);
    if (m_mode == btis_pkg::StPass || m_mode == btis_pkg::StSLost)
      seat = ($urandom_range(0, 2) != 0);
    if (m_mode == btis_pkg::StPass) press_s = ($urandom_range(0, 7) == 0);
    return mk_tick(!press_s, !press_b, seat, 12'($urandom()), 7'($urandom()),
                   ($urandom_range(0, 3) != 0));
  endfunction

  task automatic cfg_write(logic [btis_pkg::CfgIdxBits-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    reg_val[idx] = (idx == btis_pkg::RegMaxFails || idx == btis_pkg::RegHumReads) ?
                   (val & 16'h7) : val;
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !in_ch.valid && expected_words.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      in_gap = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_words.pop_front();
        in_gap = draw_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    btis_pkg::out_word_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          want = expected_words.pop_front();
          if (got.message !== want.message || got.sample_value !== want.sample_value ||
              got.machine_state !== want.machine_state ||
              got.green_led !== want.green_led || got.yellow_led !== want.yellow_led ||
              got.red_led !== want.red_led || got.engine_enable !== want.engine_enable ||
              got.buzzer_trigger !== want.buzzer_trigger || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected msg=%0d val=%0d st=%0d grn/yel/red=%b%b%b",
                       want.message, want.sample_value, want.machine_state,
                       want.green_led, want.yellow_led, want.red_led,
                       " eng=%b buz=%b last=%b,", want.engine_enable,
                       want.buzzer_trigger, want.last,
                       " got msg=%0d val=%0d st=%0d grn/yel/red=%b%b%b",
                       got.message, got.sample_value, got.machine_state,
                       got.green_led, got.yellow_led, got.red_led,
                       " eng=%b buz=%b last=%b", got.engine_enable,
                       got.buzzer_trigger, got.last);
          end
        end
        out_wait = draw_gap();
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    mismatches = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    model_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short timings so one pass covers the whole sequence
    cfg_write(btis_pkg::RegSamplePeriod, 2);
    cfg_write(btis_pkg::RegMeasureTime, 4);
    cfg_write(btis_pkg::RegSeatLost, 3);
    cfg_write(btis_pkg::RegResultTo, 4);
    cfg_write(btis_pkg::RegRetryDelay, 2);
    cfg_write(btis_pkg::RegHumPeriod, 1);
    cfg_write(btis_pkg::RegMaxFails, 2);
    cfg_write(btis_pkg::RegHumReads, 2);
    cfg_done();

    // directed walk: start, seat, blow, measure with extreme samples, verdicts
    send(mk_tick(0, 1, 0, 0, 0, 1));
    send(mk_tick(1, 1, 1, 0, 0, 1));
    send(mk_tick(1, 0, 1, 12'hFFF, 7'h7F, 1));
    send(mk_tick(1, 1, 1, 12'h000, 7'h00, 0));
    send(mk_tick(1, 1, 1, 12'hFFF, 7'h64, 1));
    send(mk_tick(1, 1, 1, 12'h000, 7'h00, 1));
    send(mk_cmd(btis_pkg::CmdOther));
    send(mk_cmd(btis_pkg::CmdFail));
    send(mk_tick(1, 1, 1, 0, 0, 1));
    send(mk_tick(1, 1, 1, 0, 0, 1));
    send(mk_tick(1, 0, 1, 0, 0, 1));
    send(mk_cmd(btis_pkg::CmdFail));
    send(mk_tick(1, 1, 1, 0, 0, 1));
    send(mk_tick(0, 1, 1, 0, 0, 1));
    send(mk_cmd(btis_pkg::CmdPass));
    send(mk_tick(1, 1, 0, 0, 0, 1));
    send(mk_tick(1, 1, 0, 0, 0, 1));
    send(mk_tick(1, 1, 0, 0, 0, 1));
    send(mk_tick(1, 1, 0, 0, 0, 1));
    send(mk_cmd(btis_pkg::CmdRetry));
    send(mk_cmd(btis_pkg::CmdError));
    send(mk_cmd(3'd5));
    send(mk_cmd(3'd6));
    send(mk_cmd(3'd7));
    drain();

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: for (int r = 0; r < btis_pkg::NumRegs; r++)
             cfg_write(btis_pkg::CfgIdxBits'(r), 16'($urandom_range(1, 12)));
        1: for (int r = 0; r < btis_pkg::NumRegs; r++)
             cfg_write(btis_pkg::CfgIdxBits'(r), 16'h0000);
        2: for (int r = 0; r < btis_pkg::NumRegs; r++)
             cfg_write(btis_pkg::CfgIdxBits'(r), 16'hFFFF);
        3: begin
          for (int r = 0; r < 6; r++)
            cfg_write(btis_pkg::CfgIdxBits'(r), 16'($urandom_range(1, 40)));
          cfg_write(btis_pkg::RegMaxFails, 7);
          cfg_write(btis_pkg::RegHumReads, 7);
        end
        default: for (int r = 0; r < btis_pkg::NumRegs; r++)
                   cfg_write(btis_pkg::CfgIdxBits'(r), 16'($urandom_range(0, 8)));
      endcase
      cfg_done();
      for (int i = 0; i < 55; i++) send(steer());
      drain();
    end

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/btis_pkg.sv
src/btis_if.sv
src/btis_front.sv
src/btis_back.sv
src/breath_test_interlock_sequencer.sv
src/btis_checker.sv
test/breath_test_interlock_sequencer_tb.sv
